// ===== sv/kfar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfar_pkg
// Shared constants, the lead/trail interval table and the control structs
// of the kanji font address resolver.
// ----------------------------------------------------------------------------
package kfar_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 512;

  localparam logic [15:0] RANGE1_LO  = 16'h8140;
  localparam logic [15:0] RANGE1_END = 16'h84BF;
  localparam logic [15:0] RANGE2_LO  = 16'h889F;
  localparam logic [15:0] RANGE2_END = 16'h9873;

  localparam logic [31:0] BASE1   = 32'hBFC66000;
  localparam logic [31:0] BASE2   = 32'hBFC69D68;
  localparam logic [31:0] ROM_LO  = 32'hBFC00000;
  localparam logic [31:0] ROM_HI  = 32'hBFC80000;
  localparam logic [31:0] NO_ADDR = 32'hFFFFFFFF;

  localparam logic [8:0] LEAD_OFFSET = 9'h111;
  localparam logic [7:0] TRAIL_SPLIT = 8'h7F;
  localparam logic [8:0] TABLE2_BASE = 9'd19;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_NEED_SEL = 2'd3;

  localparam int unsigned NUM_RULES = 19;

  // {lead, trail low (incl), trail high (excl)}
  localparam logic [23:0] RULES [NUM_RULES] = '{
    24'h81407F, 24'h8180AD, 24'h81B8C0, 24'h81C8CF, 24'h81DAE9,
    24'h81F0F8, 24'h81FCFD, 24'h824F59, 24'h82607A, 24'h82819B,
    24'h829FF2, 24'h83407F, 24'h838097, 24'h839FB7, 24'h83BFD7,
    24'h844061, 24'h84707F, 24'h848092, 24'h849FBF
  };

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } rule_hit_t;

  typedef struct packed {
    logic wr;       // store write item
    logic load;     // latch resolve item
    logic rd_main;  // read selected record
    logic calc;     // form index and record difference
    logic mul;      // form address
    logic scan_rd;  // read next selector record
    logic emit;     // register result
  } cmd_t;

  typedef struct packed {
    logic scan_need;
    logic scan_last;
  } sts_t;

  function automatic rule_hit_t rule_match(input logic [15:0] code);
    rule_hit_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = NUM_RULES - 1; i >= 0; i--) begin
      if (code[15:8] == RULES[i][23:16] && code[7:0] >= RULES[i][15:8] &&
          code[7:0] < RULES[i][7:0]) begin
        r.hit = 1'b1;
        r.idx = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/kfar_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfar_ctrl
// Sequencer: record read, address build, optional selector scan, result.
// ----------------------------------------------------------------------------
module kfar_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            mode_i,
  input  kfar_pkg::sts_t  sts_i,
  output kfar_pkg::cmd_t  cmd_o,
  output logic            busy,
  output logic            result_valid_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       valid_q;
  logic       accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd_o         = '0;
    cmd_o.wr      = accept && !mode_i;
    cmd_o.load    = accept && mode_i;
    cmd_o.rd_main = (state_q == S_RD);
    cmd_o.calc    = (state_q == S_CALC);
    cmd_o.mul     = (state_q == S_MUL);
    cmd_o.scan_rd = (state_q == S_SCAN);
    cmd_o.emit    = (state_q == S_EMIT);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && mode_i) state_d = S_RD;
      S_RD:    state_d = S_CALC;
      S_CALC:  state_d = S_MUL;
      S_MUL:   state_d = sts_i.scan_need ? S_SCAN : S_EMIT;
      S_SCAN:  if (sts_i.scan_last) state_d = S_DRAIN;
      S_DRAIN: state_d = S_EMIT;
      S_EMIT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == S_EMIT);
    end
  end

  assign result_valid_o = valid_q;

endmodule

// ===== sv/kfar_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfar_datapath
// Record store, slot selection, address arithmetic, scan compare and
// result registers.
// ----------------------------------------------------------------------------
module kfar_datapath #(
  parameter int unsigned STORE_DEPTH = kfar_pkg::STORE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  kfar_pkg::cmd_t  cmd_i,
  output kfar_pkg::sts_t  sts_o,
  input  logic [15:0]     code_i,
  input  logic [7:0]      selector_i,
  input  logic            selector_present_i,
  input  logic [31:0]     span_length_i,
  input  logic [8:0]      write_index_i,
  input  logic [15:0]     write_first_i,
  input  logic [15:0]     write_second_i,
  output logic [1:0]      status_o,
  output logic [19:0]     rom_offset_o,
  output logic [31:0]     glyph_address_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic [31:0]    mem_q [STORE_DEPTH];
  logic [31:0]    rdata_q;
  logic [AW-1:0]  raddr;

  logic [15:0]    code_q;
  logic [31:0]    span_q;
  logic [AW-1:0]  slot_q;
  logic           rej_q, range2_q, scan_need_q;
  logic [31:0]    diff_q, addr_q;
  logic [16:0]    ref_q;
  logic [7:0]     cnt_q;
  logic           scan_v_q, amb_q;
  logic [1:0]     status_q;
  logic [19:0]    offs_q;
  logic [31:0]    glyph_q;

  kfar_pkg::rule_hit_t rm;
  logic        in1, in2;
  logic [7:0]  sel8;
  logic [8:0]  rec9, slot9;
  logic [16:0] scan_diff;
  logic [31:0] base, room, addr_d;
  logic [1:0]  status_d;

  // resolve item slot selection
  always_comb begin
    rm   = kfar_pkg::rule_match(code_i);
    in1  = (code_i >= kfar_pkg::RANGE1_LO) && (code_i < kfar_pkg::RANGE1_END);
    in2  = (code_i >= kfar_pkg::RANGE2_LO) && (code_i < kfar_pkg::RANGE2_END);
    sel8 = selector_present_i ? selector_i : 8'd0;
    rec9 = {code_i[15:8], 1'b0} + {8'd0, code_i[7:0] >= kfar_pkg::TRAIL_SPLIT}
           - kfar_pkg::LEAD_OFFSET;
    if (in1) begin
      slot9 = rm.hit ? {4'd0, rm.idx} : {1'b0, sel8};
    end else begin
      slot9 = kfar_pkg::TABLE2_BASE + {1'b0, rec9[7:0]};
    end
  end

  always_comb begin
    raddr = slot_q;
    if (cmd_i.scan_rd) begin
      raddr = AW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (32'(write_index_i) < 32'(STORE_DEPTH))) begin
      mem_q[AW'(write_index_i)] <= {write_second_i, write_first_i};
    end
    if (cmd_i.rd_main || cmd_i.scan_rd) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // addr differs between records iff (second - first) differs: x30 is
  // one-to-one on a 17-bit difference modulo 2^32
  assign scan_diff = {1'b0, rdata_q[31:16]} - {1'b0, rdata_q[15:0]};

  always_comb begin
    base   = range2_q ? kfar_pkg::BASE2 : kfar_pkg::BASE1;
    addr_d = base + (diff_q << 5) - (diff_q << 1);
    if (rej_q) begin
      addr_d = kfar_pkg::NO_ADDR;
    end
  end

  always_comb begin
    room = kfar_pkg::ROM_HI - addr_q;
    priority if (amb_q) begin
      status_d = kfar_pkg::ST_NEED_SEL;
    end else if (addr_q == kfar_pkg::NO_ADDR) begin
      status_d = kfar_pkg::ST_REJECTED;
    end else if (addr_q < kfar_pkg::ROM_LO || addr_q > kfar_pkg::ROM_HI ||
                 span_q > room) begin
      status_d = kfar_pkg::ST_OUTSIDE;
    end else begin
      status_d = kfar_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_v_q <= cmd_i.scan_rd;
    if (cmd_i.load) begin
      code_q      <= code_i;
      span_q      <= span_length_i;
      slot_q      <= AW'(slot9);
      rej_q       <= !in1 && !in2;
      range2_q    <= in2;
      scan_need_q <= in1 && !rm.hit && !selector_present_i;
    end
    if (cmd_i.calc) begin
      diff_q <= {16'd0, code_q} - {16'd0, rdata_q[15:0]} + {16'd0, rdata_q[31:16]};
      ref_q  <= scan_diff;
      amb_q  <= 1'b0;
      cnt_q  <= 8'd1;
    end
    if (cmd_i.mul) begin
      addr_q <= addr_d;
    end
    if (cmd_i.scan_rd) begin
      cnt_q <= cnt_q + 8'd1;
    end
    if (scan_v_q && (scan_diff != ref_q)) begin
      amb_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      status_q <= status_d;
      offs_q   <= (status_d == kfar_pkg::ST_OK) ? 20'(addr_q - kfar_pkg::ROM_LO) : 20'd0;
      glyph_q  <= addr_q;
    end
  end

  assign sts_o.scan_need = scan_need_q;
  assign sts_o.scan_last = (cnt_q == 8'hFF);

  assign status_o        = status_q;
  assign rom_offset_o    = offs_q;
  assign glyph_address_o = glyph_q;

endmodule

// ===== sv/kanji_font_address_resolver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kanji_font_address_resolver
// Shift-JIS code to kanji glyph ROM address, with a loadable record store.
// ----------------------------------------------------------------------------
// A write item completes at its accept edge with no result; busy stays low.
// A resolve item passes record read, index build and address build states; a
// first-range code that matches no rule, sent without a selector, adds a scan of
// selector records 1..255 through the single store read port. One item at a time.
// Reset clears the sequencer only; record store contents are undefined until
// written. The result strobe lasts one cycle and cannot be held off.
module kanji_font_address_resolver #(
  parameter int unsigned STORE_DEPTH = kfar_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [15:0] code_i,
  input  logic [7:0]  selector_i,
  input  logic        selector_present_i,
  input  logic [31:0] span_length_i,
  input  logic [8:0]  write_index_i,
  input  logic [15:0] write_first_i,
  input  logic [15:0] write_second_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [19:0] rom_offset_o,
  output logic [31:0] glyph_address_o
);

  kfar_pkg::cmd_t cmd;
  kfar_pkg::sts_t sts;

  kfar_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .mode_i         (mode_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  kfar_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .code_i             (code_i),
    .selector_i         (selector_i),
    .selector_present_i (selector_present_i),
    .span_length_i      (span_length_i),
    .write_index_i      (write_index_i),
    .write_first_i      (write_first_i),
    .write_second_i     (write_second_i),
    .status_o           (status_o),
    .rom_offset_o       (rom_offset_o),
    .glyph_address_o    (glyph_address_o)
  );

endmodule

// ===== sv/kfar_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfar_checker
// Port-level checks of the resolver, module kfar_sva, bound to the top level.
// ----------------------------------------------------------------------------
module kfar_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_i,
  input logic        mode_i,
  input logic        result_valid_i,
  input logic [1:0]  status_i,
  input logic [19:0] rom_offset_i,
  input logic [31:0] glyph_address_i
);

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i |=> !result_valid_i)
    else $error("result strobe longer than one cycle");

  a_resolve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && mode_i) |=> busy_i && !result_valid_i)
    else $error("resolve item did not raise busy");

  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && !mode_i) |=> !busy_i)
    else $error("write item held the block busy");

  a_reject_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && status_i == kfar_pkg::ST_REJECTED) |->
      glyph_address_i == kfar_pkg::NO_ADDR)
    else $error("rejected item without all-ones address");

  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_i && status_i != kfar_pkg::ST_OK) |-> rom_offset_i == 20'd0)
    else $error("offset set on failed item");

endmodule

bind kanji_font_address_resolver kfar_sva u_kfar_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start),
  .busy_i          (busy),
  .mode_i          (mode_i),
  .result_valid_i  (result_valid_o),
  .status_i        (status_o),
  .rom_offset_i    (rom_offset_o),
  .glyph_address_i (glyph_address_o)
);

// ===== test/kfar_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfar_checker
// Watches the item and result channels of the kanji font address resolver.
// Keeps a shadow of the record store, predicts the status, ROM offset and
// glyph address of every resolve item, and compares each result strobe
// with the oldest prediction.
// ----------------------------------------------------------------------------
module kfar_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic                mode_i,
  input  logic [15:0]         code_i,
  input  logic [7:0]          selector_i,
  input  logic                selector_present_i,
  input  logic [31:0]         span_length_i,
  input  logic [8:0]          write_index_i,
  input  logic [15:0]         write_first_i,
  input  logic [15:0]         write_second_i,
  input  logic                result_valid_i,
  input  logic [1:0]          status_i,
  input  logic [19:0]         rom_offset_i,
  input  logic [31:0]         glyph_address_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output logic [3:0][15:0]    status_seen_o
);

  localparam logic [31:0] LOW_TABLE_BASE  = 32'hBFC66000;
  localparam logic [31:0] HIGH_TABLE_BASE = 32'hBFC69D68;
  localparam logic [31:0] ROM_START       = 32'hBFC00000;
  localparam logic [31:0] ROM_END         = 32'hBFC80000;
  localparam logic [31:0] NO_GLYPH        = 32'hFFFFFFFF;

  // lead, first trail, trail bound (exclusive)
  localparam logic [23:0] GAP_SPANS [19] = '{
    24'h81407F, 24'h8180AD, 24'h81B8C0, 24'h81C8CF, 24'h81DAE9,
    24'h81F0F8, 24'h81FCFD, 24'h824F59, 24'h82607A, 24'h82819B,
    24'h829FF2, 24'h83407F, 24'h838097, 24'h839FB7, 24'h83BFD7,
    24'h844061, 24'h84707F, 24'h848092, 24'h849FBF
  };

  typedef struct packed {
    logic [15:0] code;
    logic [1:0]  status;
    logic [19:0] rom_offset;
    logic [31:0] glyph_address;
  } glyph_result_t;

  logic [31:0]      record_mem [512];
  glyph_result_t    expected_q [$];
  int unsigned      fails;
  logic [3:0][15:0] seen;

  function automatic logic [31:0] glyph_address_for(input logic [15:0] code,
                                                    input logic [7:0]  sel);
    logic [31:0] base;
    logic [31:0] rec;
    logic [8:0]  slot;
    logic [7:0]  lead;
    logic [7:0]  trail;
    logic [7:0]  half;
    lead  = code[15:8];
    trail = code[7:0];
    if (code >= 16'h8140 && code < 16'h84BF) begin
      base = LOW_TABLE_BASE;
    end else if (code >= 16'h889F && code < 16'h9873) begin
      base = HIGH_TABLE_BASE;
    end else begin
      return NO_GLYPH;
    end
    if (lead <= 8'h84) begin
      slot = {1'b0, sel};
      for (int i = 18; i >= 0; i--) begin
        if (lead == GAP_SPANS[i][23:16] && trail >= GAP_SPANS[i][15:8] &&
            trail < GAP_SPANS[i][7:0]) begin
          slot = 9'(i);
        end
      end
    end else begin
      half = 8'({lead, 1'b0} + {8'd0, (trail >= 8'h7F)} - 9'h111);
      slot = 9'd19 + {1'b0, half};
    end
    rec = record_mem[slot];
    return base + ({16'd0, code} - {16'd0, rec[15:0]} + {16'd0, rec[31:16]}) * 32'd30;
  endfunction

  function automatic glyph_result_t resolve_expect(input logic [15:0] code,
                                                   input logic [7:0]  sel,
                                                   input logic        present,
                                                   input logic [31:0] span);
    glyph_result_t r;
    logic [31:0]   addr;
    logic          ambiguous;
    addr      = glyph_address_for(code, present ? sel : 8'd0);
    ambiguous = 1'b0;
    if (!present) begin
      for (int c = 1; c < 256; c++) begin
        if (glyph_address_for(code, 8'(c)) != addr) ambiguous = 1'b1;
      end
    end
    r.code          = code;
    r.rom_offset    = '0;
    r.glyph_address = addr;
    if (ambiguous) begin
      r.status = kfar_pkg::ST_NEED_SEL;
    end else if (addr == NO_GLYPH) begin
      r.status = kfar_pkg::ST_REJECTED;
    end else if (addr < ROM_START || addr > ROM_END || span > ROM_END - addr) begin
      r.status = kfar_pkg::ST_OUTSIDE;
    end else begin
      r.status     = kfar_pkg::ST_OK;
      r.rom_offset = 20'(addr - ROM_START);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    glyph_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      fails = 0;
      seen  = '0;
    end else begin
      if (result_valid_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d address %h",
                   $time, status_i, glyph_address_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: code %h status expected %0d, got %0d",
                     $time, want.code, want.status, status_i);
            fails++;
          end
          if (rom_offset_i !== want.rom_offset) begin
            $display("%0t: code %h rom offset expected %h, got %h",
                     $time, want.code, want.rom_offset, rom_offset_i);
            fails++;
          end
          if (glyph_address_i !== want.glyph_address) begin
            $display("%0t: code %h glyph address expected %h, got %h",
                     $time, want.code, want.glyph_address, glyph_address_i);
            fails++;
          end
          seen[want.status] = seen[want.status] + 16'd1;
        end
      end
      if (start_i && !busy_i) begin
        if (mode_i) begin
          expected_q.push_back(resolve_expect(code_i, selector_i, selector_present_i,
                                              span_length_i));
        end else begin
          record_mem[write_index_i] = {write_second_i, write_first_i};
        end
      end
    end
    pending_o     <= expected_q.size();
    fail_count_o  <= fails;
    status_seen_o <= seen;
  end

endmodule

// ===== test/tb_kanji_font_address_resolver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kanji_font_address_resolver
// Stimulus and verdict for the kanji font address resolver. Loads the record
// store with realistic, uniform-difference and scrambled records, then sends
// directed and random resolve items mixed with store writes; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_kanji_font_address_resolver;

  localparam int STALL_LIMIT = 2000;

  typedef enum int {PROF_REALISTIC, PROF_UNIFORM, PROF_SCRAMBLED} store_profile_e;

  localparam logic [15:0] EDGE_CODES [8] = '{
    16'h813F, 16'h8140, 16'h84BE, 16'h84BF, 16'h889E, 16'h889F, 16'h9872, 16'h9873
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        mode_i = 1'b0;
  logic [15:0] code_i = '0;
  logic [7:0]  selector_i = '0;
  logic        selector_present_i = 1'b0;
  logic [31:0] span_length_i = '0;
  logic [8:0]  write_index_i = '0;
  logic [15:0] write_first_i = '0;
  logic [15:0] write_second_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [19:0] rom_offset_o;
  logic [31:0] glyph_address_o;

  int unsigned      fail_count;
  int unsigned      pending;
  logic [3:0][15:0] status_seen;

  int          stall_cycles = 0;
  int          n_writes = 0;
  int          n_resolves = 0;
  int          broken_slot = -1;
  int          uniform_delta = 0;
  bit          gaps_on = 1'b1;

  kanji_font_address_resolver u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .code_i             (code_i),
    .selector_i         (selector_i),
    .selector_present_i (selector_present_i),
    .span_length_i      (span_length_i),
    .write_index_i      (write_index_i),
    .write_first_i      (write_first_i),
    .write_second_i     (write_second_i),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .rom_offset_o       (rom_offset_o),
    .glyph_address_o    (glyph_address_o)
  );

  kfar_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .mode_i             (mode_i),
    .code_i             (code_i),
    .selector_i         (selector_i),
    .selector_present_i (selector_present_i),
    .span_length_i      (span_length_i),
    .write_index_i      (write_index_i),
    .write_first_i      (write_first_i),
    .write_second_i     (write_second_i),
    .result_valid_i     (result_valid_o),
    .status_i           (status_o),
    .rom_offset_i       (rom_offset_o),
    .glyph_address_i    (glyph_address_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .status_seen_o      (status_seen)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_item(input logic m, input logic [15:0] code, input logic [7:0] sel,
                           input logic present, input logic [31:0] span,
                           input logic [8:0] idx, input logic [15:0] first,
                           input logic [15:0] second);
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start              <= 1'b1;
    mode_i             <= m;
    code_i             <= code;
    selector_i         <= sel;
    selector_present_i <= present;
    span_length_i      <= span;
    write_index_i      <= idx;
    write_first_i      <= first;
    write_second_i     <= second;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // unused fields carry noise
  task automatic write_record(input int slot, input logic [31:0] rec);
    send_item(1'b0, 16'($urandom), 8'($urandom), 1'($urandom), $urandom,
              9'(slot), rec[15:0], rec[31:16]);
    n_writes++;
  endtask

  task automatic resolve_code(input logic [15:0] code, input logic [7:0] sel,
                              input logic present, input logic [31:0] span);
    send_item(1'b1, code, sel, present, span, 9'($urandom), 16'($urandom),
              16'($urandom));
    n_resolves++;
  endtask

  // record words are {second, first}
  function automatic logic [31:0] record_for(input store_profile_e prof, input int slot);
    logic [15:0] first;
    logic [15:0] second;
    logic [8:0]  pair;
    case (prof)
      PROF_REALISTIC: begin
        if (slot < 19) begin
          first = kfar_pkg::RULES[slot][23:8];
        end else if (slot <= 50) begin
          pair  = 9'(slot - 19) + 9'h111;
          first = {pair[8:1], pair[0] ? 8'h7F : 8'h40};
        end else begin
          first = 16'($urandom_range(16'h8140, 16'h84BE));
        end
        second = 16'($urandom_range(0, 2500));
      end
      PROF_UNIFORM: begin
        first  = 16'($urandom_range(16'h8140, 16'hFFFF));
        second = 16'(first - 16'h8140 + 16'(uniform_delta));
      end
      default: begin
        first  = 16'($urandom);
        second = 16'($urandom);
      end
    endcase
    return {second, first};
  endfunction

  function automatic logic [15:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'($urandom_range(16'h8140, 16'h84BE));
    if (r < 65) return 16'($urandom_range(16'h889F, 16'h9872));
    if (r < 85) return EDGE_CODES[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 256);
    if (r < 60) return $urandom_range(0, 32'h20000);
    if (r < 70) return 32'd0;
    if (r < 80) return 32'hFFFFFFFF - $urandom_range(0, 15);
    return $urandom;
  endfunction

  task automatic fill_store(input store_profile_e prof, input int last_slot);
    for (int s = 0; s <= last_slot; s++) write_record(s, record_for(prof, s));
  endtask

  task automatic run_mix(input store_profile_e prof, input int count);
    int slot;
    for (int n = 0; n < count; n++) begin
      gaps_on = !(n >= count / 3 && n < count / 3 + count / 4);
      if ($urandom_range(0, 99) < 15) begin
        case (prof)
          PROF_REALISTIC: begin
            slot = $urandom_range(0, 274);
            write_record(slot, ($urandom_range(0, 9) == 0) ? $urandom :
                               record_for(prof, slot));
          end
          PROF_UNIFORM: begin
            // one odd record at a time, repaired by the next write
            if (broken_slot >= 0) begin
              write_record(broken_slot, record_for(prof, broken_slot));
              broken_slot = -1;
            end else if ($urandom_range(0, 99) < 30) begin
              broken_slot = $urandom_range(0, 255);
              write_record(broken_slot, $urandom);
            end else begin
              slot = $urandom_range(0, 274);
              write_record(slot, record_for(prof, slot));
            end
          end
          default: write_record($urandom_range(0, 511), $urandom);
        endcase
      end else begin
        resolve_code(pick_code(), 8'($urandom), 1'($urandom_range(0, 1)), pick_span());
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_store(PROF_REALISTIC, 274);

    // directed: span limits, extremes, code range edges
    write_record(0, {16'h0000, 16'h8140});
    write_record(511, 32'hFFFFFFFF);
    write_record(255, {16'hFFFF, 16'h0000});
    resolve_code(16'h8140, 8'h00, 1'b1, 32'h0001A000);
    resolve_code(16'h8140, 8'h00, 1'b1, 32'h0001A001);
    resolve_code(16'h8140, 8'hFF, 1'b1, 32'hFFFFFFFF);
    resolve_code(16'h8140, 8'h00, 1'b0, 32'h00000000);
    resolve_code(16'h81FE, 8'hFF, 1'b1, 32'h00000000);
    resolve_code(16'h81FE, 8'h00, 1'b0, 32'h00000000);
    resolve_code(16'h0000, 8'h00, 1'b0, 32'h00000000);
    resolve_code(16'hFFFF, 8'hFF, 1'b1, 32'hFFFFFFFF);
    resolve_code(16'h813F, 8'h13, 1'b1, 32'h00000010);
    resolve_code(16'h84BF, 8'h00, 1'b0, 32'h00000010);
    resolve_code(16'h889E, 8'h40, 1'b1, 32'h00000010);
    resolve_code(16'h9873, 8'h00, 1'b0, 32'h00000010);
    resolve_code(16'h84BE, 8'h00, 1'b0, 32'h00000020);
    resolve_code(16'h889F, 8'h55, 1'b1, 32'h00000020);
    resolve_code(16'h9872, 8'h00, 1'b0, 32'h00000020);
    resolve_code(16'h897E, 8'hAA, 1'b1, 32'h00000100);
    resolve_code(16'h897F, 8'h00, 1'b0, 32'h00000100);
    resolve_code(16'h82FF, 8'h33, 1'b1, 32'h00001000);
    resolve_code(16'h8480, 8'hCC, 1'b0, 32'h00001000);

    run_mix(PROF_REALISTIC, 120);

    uniform_delta = $urandom_range(0, 2600);
    fill_store(PROF_UNIFORM, 274);
    run_mix(PROF_UNIFORM, 120);

    fill_store(PROF_SCRAMBLED, 274);
    run_mix(PROF_SCRAMBLED, 60);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d store writes and %0d resolves over three store profiles.",
             n_writes, n_resolves);
    $display("Results by status: ok %0d, rejected %0d, outside ROM %0d, need selector %0d",
             status_seen[kfar_pkg::ST_OK], status_seen[kfar_pkg::ST_REJECTED],
             status_seen[kfar_pkg::ST_OUTSIDE], status_seen[kfar_pkg::ST_NEED_SEL]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
